// ----- rtl/blecw_pkg.sv -----
// Shared types, constants and bit-step functions for the advertising transmit coder.
`default_nettype none

package blecw_pkg;

    localparam logic [23:0] CRC_SEED    = 24'hAAAAAA;
    localparam logic [7:0]  CRC_TAP_LOW = 8'hDA;
    localparam logic [7:0]  CRC_TAP_MID = 8'h60;
    localparam logic [7:0]  WHITEN_TAPS = 8'h88;
    localparam logic [6:0]  WHITEN_BIT6 = 7'h40;
    localparam logic [5:0]  CHANNEL_RESET = 6'd37;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] wire_byte;
        logic       is_crc;
        logic       end_of_packet;
    } t_out_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       first_byte;
    } t_queue_entry;

    typedef struct packed {
        logic [7:0] mask;
        logic [6:0] lfsr;
    } t_whiten;

    function automatic logic [23:0] crc_feed(input logic [23:0] crc, input logic [7:0] d);
        logic [7:0] hi;
        logic [7:0] mid;
        logic [7:0] lo;
        logic       fb;
        hi  = crc[23:16];
        mid = crc[15:8];
        lo  = crc[7:0];
        for (int i = 0; i < 8; i++) begin
            fb  = hi[0];
            hi  = {mid[0], hi[7:1]};
            mid = {lo[0], mid[7:1]};
            lo  = {1'b0, lo[7:1]};
            if (fb != d[i]) begin
                lo  = lo ^ CRC_TAP_LOW;
                mid = mid ^ CRC_TAP_MID;
            end
        end
        return {hi, mid, lo};
    endfunction

    function automatic t_whiten whiten_byte(input logic [6:0] lfsr);
        logic [7:0] l;
        logic [7:0] res;
        t_whiten    w;
        l   = {1'b0, lfsr};
        res = '0;
        for (int i = 0; i < 8; i++) begin
            if (l[0]) begin
                l      = l ^ WHITEN_TAPS;
                res[i] = 1'b1;
            end
            l = {1'b0, l[7:1]};
        end
        w.mask = res;
        w.lfsr = l[6:0];
        return w;
    endfunction

    function automatic logic [7:0] bit_reverse8(input logic [7:0] a);
        logic [7:0] v;
        for (int i = 0; i < 8; i++) begin
            v[7 - i] = a[i];
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/blecw_front.sv -----
// Input front end: accepts bytes, tags packet openings and queues them for the coder.
`default_nettype none

module blecw_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_in_valid,
    output logic                    o_in_stall,
    input  blecw_pkg::t_in_item     i_in_item,
    output logic                    o_q_valid,
    output blecw_pkg::t_queue_entry o_q_entry,
    input  wire                     i_q_pop
);
    import blecw_pkg::*;

    t_queue_entry      r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              r_start;
    logic              push;
    logic              pop;

    assign o_in_stall = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_valid  = (r_count != '0);
    assign o_q_entry  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_start  <= 1'b1;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
                r_start  <= i_in_item.last_byte;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{data_byte:  i_in_item.data_byte,
                                 last_byte:  i_in_item.last_byte,
                                 first_byte: r_start};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/blecw_back.sv -----
// Coder back end: CRC-24 update, whitening, bit reversal and CRC byte emission.
`default_nettype none

module blecw_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_wr_en,
    input  wire [5:0]               i_cfg_wr_data,
    input  wire                     i_q_valid,
    input  blecw_pkg::t_queue_entry i_q_entry,
    output logic                    o_q_pop,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output blecw_pkg::t_out_item    o_out_item
);
    import blecw_pkg::*;

    typedef enum logic [1:0] {
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_MID,
        PH_CRC_LO
    } t_phase;

    t_phase     r_phase;
    logic [23:0] r_crc;
    logic [6:0]  r_lfsr;
    logic [5:0]  r_channel;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        out_free;
    logic [23:0] crc_base;
    logic [6:0]  lfsr_base;
    logic [23:0] n_crc;
    logic [7:0]  plain;
    t_whiten     wh;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop  = (r_phase == PH_DATA) && i_q_valid && out_free;

    always_comb begin
        crc_base  = i_q_entry.first_byte ? CRC_SEED : r_crc;
        lfsr_base = r_lfsr;
        if (r_phase == PH_DATA && i_q_entry.first_byte) begin
            lfsr_base = WHITEN_BIT6 | {1'b0, r_channel};
        end
        n_crc = crc_feed(crc_base, i_q_entry.data_byte);
        unique case (r_phase)
            PH_DATA:    plain = i_q_entry.data_byte;
            PH_CRC_HI:  plain = r_crc[23:16];
            PH_CRC_MID: plain = r_crc[15:8];
            PH_CRC_LO:  plain = r_crc[7:0];
            default:    plain = i_q_entry.data_byte;
        endcase
        wh = whiten_byte(lfsr_base);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_DATA;
            r_crc       <= CRC_SEED;
            r_lfsr      <= WHITEN_BIT6 | {1'b0, CHANNEL_RESET};
            r_channel   <= CHANNEL_RESET;
            r_out_valid <= 1'b0;
            r_out_item  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_channel <= i_cfg_wr_data;
            end
            if (out_free) begin
                r_out_valid              <= 1'b0;
                r_out_item.wire_byte     <= bit_reverse8(plain ^ wh.mask);
                r_out_item.is_crc        <= (r_phase != PH_DATA);
                r_out_item.end_of_packet <= (r_phase == PH_CRC_LO);
                unique case (r_phase)
                    PH_DATA: begin
                        if (i_q_valid) begin
                            r_out_valid <= 1'b1;
                            r_crc       <= n_crc;
                            r_lfsr      <= wh.lfsr;
                            if (i_q_entry.last_byte) begin
                                r_phase <= PH_CRC_HI;
                            end
                        end
                    end
                    PH_CRC_HI: begin
                        r_out_valid <= 1'b1;
                        r_lfsr      <= wh.lfsr;
                        r_phase     <= PH_CRC_MID;
                    end
                    PH_CRC_MID: begin
                        r_out_valid <= 1'b1;
                        r_lfsr      <= wh.lfsr;
                        r_phase     <= PH_CRC_LO;
                    end
                    PH_CRC_LO: begin
                        r_out_valid <= 1'b1;
                        r_lfsr      <= wh.lfsr;
                        r_phase     <= PH_DATA;
                    end
                    default: begin
                        r_phase <= PH_DATA;
                    end
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- rtl/ble_adv_tx_crc_whiten_coder.sv -----
// Top level of the advertising transmit coder: front queue, coder back end and checks.
//
// Input channel: one packet byte per beat (i_in_valid, o_in_stall, i_in_item), with
// last_byte set on the final payload byte. Output channel: one wire byte per beat
// (o_out_valid, i_out_stall, o_out_item); each input byte gives one beat, and the
// last byte of a packet is followed by three CRC beats, the third with end_of_packet.
// The channel register is written through i_cfg_wr_en / i_cfg_wr_data and seeds the
// whitening register at the next packet opening.
// With an empty queue an accepted byte passes first through a queue entry and then
// through the output register of the coder before it can be taken at the output.
// The coder gives one output beat per cycle while i_out_stall is low and a beat is
// ready, set by its single output register; it pops no queue byte during the three
// CRC beats that follow a last byte.
// A two-entry queue sits between the front and the coder, so input beats keep being
// taken while an output beat is stalled, until the queue fills.
// Reset empties the queue, drops any pending output beat, sets the channel to 37
// and opens a new packet. While i_out_stall is high the output beat holds.
`default_nettype none

module ble_adv_tx_crc_whiten_coder (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire [5:0]            i_cfg_wr_data,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  blecw_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output blecw_pkg::t_out_item o_out_item
);
    import blecw_pkg::*;

    logic         q_valid;
    logic         q_pop;
    t_queue_entry q_entry;

    blecw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .o_q_entry  (q_entry),
        .i_q_pop    (q_pop)
    );

    blecw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_valid     (q_valid),
        .i_q_entry     (q_entry),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_item    (o_out_item)
    );

    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_valid)
        else $error("input stalled with an empty queue");

    a_eop_is_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.end_of_packet |-> o_out_item.is_crc)
        else $error("end of packet on a non-CRC beat");

    a_crc_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out_item.is_crc && !o_out_item.end_of_packet
        |=> o_out_valid && o_out_item.is_crc)
        else $error("CRC beats not contiguous");

endmodule

`default_nettype wire
